/* src/gss_pkg.sv */
// Package for the 3x3 grid smoother: sizes, fixed-point widths, register codes,
// the structs passed between stages and the grid size clamp.
// Depends on nothing; every other file of the block imports it.
package gss_pkg;

   // Grid and sample geometry
   localparam int MaxSize    = 4096;
   localparam int MinSize    = 3;
   localparam int AddrBits   = $clog2(MaxSize);
   localparam int SizeBits   = 13;
   localparam int PosBits    = 12;
   localparam int SampleBits = 16;
   localparam int LineBits   = 2 * SampleBits;

   // Fixed-point arithmetic: Q1.15 samples, Q2.14 weights
   localparam int WeightBits = 16;
   localparam int SumBits    = SampleBits + 2;
   localparam int ProdBits   = WeightBits + SumBits + 1;
   localparam int AccBits    = ProdBits + 2;
   localparam int FracShift  = 14;
   localparam logic signed [AccBits-1:0] RoundHalf = AccBits'(1 << (FracShift - 1));

   // Configuration port
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 16;

   localparam logic [SizeBits-1:0]   GridSizeReset     = SizeBits'(4096);
   localparam logic [WeightBits-1:0] CornerWeightReset = WeightBits'(819);
   localparam logic [WeightBits-1:0] EdgeWeightReset   = WeightBits'(1638);
   localparam logic [WeightBits-1:0] CenterWeightReset = WeightBits'(6554);

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_GRID_SIZE     = 2'd0,
      CSR_CORNER_WEIGHT = 2'd1,
      CSR_EDGE_WEIGHT   = 2'd2,
      CSR_CENTER_WEIGHT = 2'd3
   } csr_index_type;

   // Raster position of the sample being accepted
   typedef struct packed {
      logic [AddrBits-1:0] addr;
      logic [PosBits-1:0]  out_row;
      logic [PosBits-1:0]  out_col;
      logic                interior;
      logic                last;
   } pos_type;

   // Grouped window sums of one interior cell
   typedef struct packed {
      logic [SumBits-1:0]    diag;
      logic [SumBits-1:0]    orth;
      logic [SampleBits-1:0] ctr;
      logic [PosBits-1:0]    out_row;
      logic [PosBits-1:0]    out_col;
      logic                  last;
   } taps_type;

   typedef struct packed {
      logic signed [WeightBits-1:0] corner_wt;
      logic signed [WeightBits-1:0] edge_wt;
      logic signed [WeightBits-1:0] center_wt;
   } weights_type;

   // Clamp the programmed grid size to the supported range
   function automatic logic [SizeBits-1:0] gss_size_in_use(input logic [SizeBits-1:0] raw);
      logic [SizeBits-1:0] s;
      s = raw;
      if (s < SizeBits'(MinSize)) begin
         s = SizeBits'(MinSize);
      end
      if (s > SizeBits'(MaxSize)) begin
         s = SizeBits'(MaxSize);
      end
      return s;
   endfunction

endpackage

/* src/gss_if.sv */
// Valid/ready channel interfaces for the grid smoother: sample input and result output.
// Depends on gss_pkg for the field widths.
interface gss_req_if;
   import gss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SampleBits-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface gss_rsp_if;
   import gss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SampleBits-1:0] smoothed;
   logic [PosBits-1:0]    out_row;
   logic [PosBits-1:0]    out_col;
   logic                  frame_last;

   modport source (output valid, output smoothed, output out_row, output out_col,
                   output frame_last, input ready);
   modport sink   (input valid, input smoothed, input out_row, input out_col,
                   input frame_last, output ready);
endinterface

/* src/gss_pos_ctr.sv */
// Raster position counters of the grid smoother: row and column of the next sample.
// Depends on gss_pkg for widths, the position struct and the size clamp.
module gss_pos_ctr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [gss_pkg::SizeBits-1:0] grid_size,
   input  logic                         advance,
   output gss_pkg::pos_type             pos
);
   import gss_pkg::*;

   logic [PosBits-1:0]  row_ff, row_in;
   logic [PosBits-1:0]  col_ff, col_in;
   logic [SizeBits-1:0] size;
   logic                wrap_col;
   logic [SizeBits-1:0] row_step;
   logic [PosBits-1:0]  cur_row, cur_col;
   logic [SizeBits-1:0] col_inc, row_inc;

   assign size = gss_size_in_use(grid_size);

   // Wrap a position left past the grid (size shrank since the last sample)
   always_comb begin
      wrap_col = ({1'b0, col_ff} >= size);
      cur_col  = wrap_col ? '0 : col_ff;
      row_step = wrap_col ? ({1'b0, row_ff} + SizeBits'(1)) : {1'b0, row_ff};
      cur_row  = (row_step >= size) ? '0 : row_step[PosBits-1:0];
   end

   // Step to the next raster position, wrapping at the row and grid end
   always_comb begin
      col_inc = {1'b0, cur_col} + SizeBits'(1);
      row_inc = {1'b0, cur_row} + SizeBits'(1);
      if (col_inc >= size) begin
         col_in = '0;
         row_in = (row_inc >= size) ? '0 : row_inc[PosBits-1:0];
      end else begin
         col_in = col_inc[PosBits-1:0];
         row_in = cur_row;
      end
   end

   always_comb begin
      pos.addr     = cur_col[AddrBits-1:0];
      pos.out_row  = cur_row - PosBits'(1);
      pos.out_col  = cur_col - PosBits'(1);
      pos.interior = (cur_row >= PosBits'(2)) && (cur_col >= PosBits'(2));
      pos.last     = ({1'b0, cur_row} == size - SizeBits'(1)) &&
                     ({1'b0, cur_col} == size - SizeBits'(1));
   end

   // Advance on each sample transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

/* src/gss_line_buf.sv */
// Line buffer of the grid smoother: one memory holding the two previous rows side by side.
// Depends on gss_pkg for depth and width; one write and one registered read per cycle.
module gss_line_buf (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [gss_pkg::AddrBits-1:0] wr_addr,
   input  logic [gss_pkg::LineBits-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [gss_pkg::AddrBits-1:0] rd_addr,
   output logic [gss_pkg::LineBits-1:0] rd_data
);
   import gss_pkg::*;

   logic [LineBits-1:0] mem [MaxSize];
   logic [LineBits-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/gss_window.sv */
// 3x3 window of the grid smoother: sample stage, window registers, line buffer
// write-back and the grouped neighbor sums. Depends on gss_pkg.
module gss_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [gss_pkg::SampleBits-1:0] sample,
   input  gss_pkg::pos_type               pos,
   input  logic [gss_pkg::LineBits-1:0]   line_data,
   output logic                           in_free,
   output logic                           wr_en,
   output logic [gss_pkg::AddrBits-1:0]   wr_addr,
   output logic [gss_pkg::LineBits-1:0]   wr_data,
   output logic                           taps_valid,
   input  logic                           taps_ready,
   output gss_pkg::taps_type              taps
);
   import gss_pkg::*;

   logic                  s1_valid_ff;
   logic [SampleBits-1:0] s1_sample_ff;
   pos_type               s1_pos_ff;
   logic [SampleBits-1:0] win_ff [6];
   logic                  s2_valid_ff;
   taps_type              s2_taps_ff, s2_taps_in;
   logic                  s2_free, s1_adv;
   logic [SampleBits-1:0] top, mid;

   assign top = line_data[LineBits-1:SampleBits];
   assign mid = line_data[SampleBits-1:0];

   // Stage handshakes: a stage loads when it is empty or emptying
   assign s2_free = !s2_valid_ff || taps_ready;
   assign s1_adv  = s1_valid_ff && s2_free;
   assign in_free = !s1_valid_ff || s2_free;

   // Write the column back: older row takes the middle, newer takes the sample
   assign wr_en   = s1_adv;
   assign wr_addr = s1_pos_ff.addr;
   assign wr_data = {mid, s1_sample_ff};

   // Neighbor sums; window slots 0..2 hold column c-2, 3..5 column c-1
   always_comb begin
      s2_taps_in.diag    = SumBits'(win_ff[0]) + SumBits'(win_ff[2]) +
                           SumBits'(top) + SumBits'(s1_sample_ff);
      s2_taps_in.orth    = SumBits'(win_ff[1]) + SumBits'(win_ff[3]) +
                           SumBits'(win_ff[5]) + SumBits'(mid);
      s2_taps_in.ctr     = win_ff[4];
      s2_taps_in.out_row = s1_pos_ff.out_row;
      s2_taps_in.out_col = s1_pos_ff.out_col;
      s2_taps_in.last    = s1_pos_ff.last;
   end

   // Sample stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_free) begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_sample_ff <= sample;
         s1_pos_ff    <= pos;
      end
   end

   // Shift the window once per sample
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_sample_ff;
      end
   end

   // Sum stage: keep interior cells only, drop border cells
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv && s1_pos_ff.interior;
      end
      if (s1_adv) begin
         s2_taps_ff <= s2_taps_in;
      end
   end

   assign taps_valid = s2_valid_ff;
   assign taps       = s2_taps_ff;

endmodule

/* src/gss_kernel.sv */
// Weighting kernel of the grid smoother: three products, then sum, rounding and
// clamp into the result register. Depends on gss_pkg and gss_rsp_if.
module gss_kernel (
   input  logic                 clock,
   input  logic                 reset,
   input  gss_pkg::weights_type weights,
   input  logic                 taps_valid,
   output logic                 taps_ready,
   input  gss_pkg::taps_type    taps,
   gss_rsp_if.source            rsp_chan
);
   import gss_pkg::*;

   logic                          s3_valid_ff;
   logic signed [ProdBits-1:0]    prod_c_ff, prod_e_ff, prod_m_ff;
   logic signed [ProdBits-1:0]    prod_c_in, prod_e_in, prod_m_in;
   logic [PosBits-1:0]            s3_row_ff, s3_col_ff;
   logic                          s3_last_ff;
   logic                          out_valid_ff;
   logic [SampleBits-1:0]         out_smoothed_ff, out_smoothed_in;
   logic [PosBits-1:0]            out_row_ff, out_col_ff;
   logic                          out_last_ff;
   logic                          out_free, s3_free;
   logic signed [WeightBits-1:0]  cw, ew, mw;
   logic signed [SumBits:0]       diag_s, orth_s;
   logic signed [SampleBits:0]    ctr_s;
   logic signed [AccBits-1:0]     acc, shifted;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign s3_free    = !s3_valid_ff || out_free;
   assign taps_ready = s3_free;

   // Products of weights and grouped sums
   always_comb begin
      cw        = weights.corner_wt;
      ew        = weights.edge_wt;
      mw        = weights.center_wt;
      diag_s    = $signed({1'b0, taps.diag});
      orth_s    = $signed({1'b0, taps.orth});
      ctr_s     = $signed({1'b0, taps.ctr});
      prod_c_in = ProdBits'(cw) * ProdBits'(diag_s);
      prod_e_in = ProdBits'(ew) * ProdBits'(orth_s);
      prod_m_in = ProdBits'(mw) * ProdBits'(ctr_s);
   end

   // Sum, round half up, drop the fraction and clamp to the sample range
   always_comb begin
      acc     = AccBits'(prod_c_ff) + AccBits'(prod_e_ff) + AccBits'(prod_m_ff) + RoundHalf;
      shifted = acc >>> FracShift;
      if (acc[AccBits-1]) begin
         out_smoothed_in = '0;
      end else if (|shifted[AccBits-1:SampleBits]) begin
         out_smoothed_in = '1;
      end else begin
         out_smoothed_in = shifted[SampleBits-1:0];
      end
   end

   // Product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= taps_valid;
      end
      if (s3_free && taps_valid) begin
         prod_c_ff  <= prod_c_in;
         prod_e_ff  <= prod_e_in;
         prod_m_ff  <= prod_m_in;
         s3_row_ff  <= taps.out_row;
         s3_col_ff  <= taps.out_col;
         s3_last_ff <= taps.last;
      end
   end

   // Result register; hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s3_valid_ff;
      end
      if (out_free && s3_valid_ff) begin
         out_smoothed_ff <= out_smoothed_in;
         out_row_ff      <= s3_row_ff;
         out_col_ff      <= s3_col_ff;
         out_last_ff     <= s3_last_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.smoothed   = out_smoothed_ff;
   assign rsp_chan.out_row    = out_row_ff;
   assign rsp_chan.out_col    = out_col_ff;
   assign rsp_chan.frame_last = out_last_ff;

endmodule

/* src/grid_3x3_symmetric_smoother_core.sv */
// 3x3 symmetric smoother over a square grid streamed in raster order.
// Channels: req_chan takes one unsigned Q1.15 sample per transfer, row by row.
// rsp_chan gives one result per interior cell: the smoothed Q1.15 value, the
// cell's row and column, and frame_last on the final interior cell of the grid.
// Border cells (first/last row and column) give no result.
// Configuration: csr_wr_en/csr_index/csr_wdata write grid size and the three
// signed Q2.14 weights; write only while no sample is in flight.
// Pipeline: the sample stage loads at the transfer of the sample that completes its
// window, then the sum stage, product stage and result register take it in turn.
// Throughput: one sample per cycle unless the receiver stalls; the line buffer memory
// does one read at the transfer and one write-back as the sample stage advances.
// Reset clears the position counters, window, weights and grid size to defaults
// and empties the pipeline; the line buffer needs no clearing pass.
// When the receiver stalls, the result holds and stages behind it fill up;
// req_chan.ready drops only once every stage is occupied.
// Depends on gss_pkg, gss_if, gss_pos_ctr, gss_line_buf, gss_window, gss_kernel.
module grid_3x3_symmetric_smoother_core (
   input  logic                            clock,
   input  logic                            reset,
   gss_req_if.sink                         req_chan,
   gss_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [gss_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [gss_pkg::CsrDataBits-1:0] csr_wdata
);
   import gss_pkg::*;

   logic [SizeBits-1:0]   grid_size_ff;
   logic [WeightBits-1:0] corner_weight_ff, edge_weight_ff, center_weight_ff;
   weights_type           weights;
   pos_type               pos;
   logic                  in_free, accept;
   logic                  wr_en;
   logic [AddrBits-1:0]   wr_addr;
   logic [LineBits-1:0]   wr_data, rd_data;
   logic                  taps_valid, taps_ready;
   taps_type              taps;
   logic [SizeBits-1:0]   size_use;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff     <= GridSizeReset;
         corner_weight_ff <= CornerWeightReset;
         edge_weight_ff   <= EdgeWeightReset;
         center_weight_ff <= CenterWeightReset;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_SIZE:     grid_size_ff     <= csr_wdata[SizeBits-1:0];
            CSR_CORNER_WEIGHT: corner_weight_ff <= csr_wdata[WeightBits-1:0];
            CSR_EDGE_WEIGHT:   edge_weight_ff   <= csr_wdata[WeightBits-1:0];
            CSR_CENTER_WEIGHT: center_weight_ff <= csr_wdata[WeightBits-1:0];
         endcase
      end
   end

   assign weights.corner_wt = $signed(corner_weight_ff);
   assign weights.edge_wt   = $signed(edge_weight_ff);
   assign weights.center_wt = $signed(center_weight_ff);
   assign size_use          = gss_size_in_use(grid_size_ff);

   // Sample transfer
   assign req_chan.ready = in_free;
   assign accept         = req_chan.valid && in_free;

   gss_pos_ctr u_pos_ctr (
      .clock     (clock),
      .reset     (reset),
      .grid_size (grid_size_ff),
      .advance   (accept),
      .pos       (pos)
   );

   gss_line_buf u_line_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (pos.addr),
      .rd_data (rd_data)
   );

   gss_window u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (req_chan.sample),
      .pos        (pos),
      .line_data  (rd_data),
      .in_free    (in_free),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .taps_valid (taps_valid),
      .taps_ready (taps_ready),
      .taps       (taps)
   );

   gss_kernel u_kernel (
      .clock      (clock),
      .reset      (reset),
      .weights    (weights),
      .taps_valid (taps_valid),
      .taps_ready (taps_ready),
      .taps       (taps),
      .rsp_chan   (rsp_chan)
   );

   // The line buffer column read at a transfer lies inside the grid in use
   assert property (@(posedge clock) disable iff (reset)
      accept |-> ({1'b0, pos.addr} < size_use))
      else $error("line buffer read beyond grid width");

   // Write-back of one column never collides with the read of the next
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept) |-> (wr_addr != pos.addr))
      else $error("line buffer read and write at the same column");

   // Results only come from interior cells
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.out_row != '0) && (rsp_chan.out_col != '0)))
      else $error("result for a border cell");

   // The last interior cell sits on the diagonal
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_last) |-> (rsp_chan.out_row == rsp_chan.out_col))
      else $error("frame_last off the diagonal");

endmodule
